/* hw/rtl/sdpc_pkg.sv */
// sdpc_pkg: shared types, register indexes and the half-step coil table
// for the stepper door position controller; no dependencies
`default_nettype none

package sdpc_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned POS_W = 16;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COIL_W = 4;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TARGET = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] STEP_INTERVAL_RST = CFG_DATA_W'(2);
    localparam logic [CFG_DATA_W-1:0] OPEN_TARGET_RST = CFG_DATA_W'(4096);

    localparam logic [MODE_W-1:0] DOOR_MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] DOOR_MODE_OPENING = 2'd1;
    localparam logic [MODE_W-1:0] DOOR_MODE_CLOSING = 2'd2;

    typedef enum logic [2:0] {
        MOTION_IDLE    = 3'b001,
        MOTION_OPENING = 3'b010,
        MOTION_CLOSING = 3'b100
    } motion_t;

    typedef struct packed {
        motion_t                mode;
        logic [TIME_W-1:0]      last_time;
        logic [POS_W-1:0]       position;
        logic [PHASE_W-1:0]     phase;
        logic [COIL_W-1:0]      coil;
    } sdpc_state_t;

    function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pattern;
        case (phase)
            3'd0:    pattern = 4'h1;
            3'd1:    pattern = 4'h3;
            3'd2:    pattern = 4'h2;
            3'd3:    pattern = 4'h6;
            3'd4:    pattern = 4'h4;
            3'd5:    pattern = 4'hC;
            3'd6:    pattern = 4'h8;
            default: pattern = 4'h9;
        endcase
        return pattern;
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input motion_t mode);
        logic [MODE_W-1:0] code;
        unique case (mode)
            MOTION_OPENING: code = DOOR_MODE_OPENING;
            MOTION_CLOSING: code = DOOR_MODE_CLOSING;
            default:        code = DOOR_MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/stepper_door_position_controller.sv */
// stepper_door_position_controller: top level with input register, state
// and result register; uses sdpc_pkg and sdpc_core
`default_nettype none

// channel   dir  fields (low bit up)
// s_axis    in   open_pressed, close_pressed, now_ms
// m_axis    out  coil_pattern, door_mode, door_position, stepped
// cfg       in   cfg_index (0 step_interval, 1 open_target_steps), cfg_data
//
// one item per cycle while m_tready does not stall; m_tvalid rises after the s_ accept once
// the item has passed the input register and the state update into the result register
// aresetn is synchronous: clears both stages, the motion state and the config registers
// a stalled m_ side holds the result; the input register still takes one item
// config writes are always ready and apply on the cycle after the transaction

module stepper_door_position_controller
    import sdpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_W-1:0]     s_tdata,   // open_pressed, close_pressed, now_ms[31:0], pad
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // coil_pattern[3:0], door_mode[1:0],
                                                // door_position[15:0], stepped, pad
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic                    in_valid_reg;
    logic                    open_reg;
    logic                    close_reg;
    logic [TIME_W-1:0]       now_reg;
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;
    logic [CFG_DATA_W-1:0]   interval_reg;
    logic [CFG_DATA_W-1:0]   target_reg;
    sdpc_state_t             state_reg;
    sdpc_state_t             state_next;
    logic                    stepped;
    logic                    advance;
    logic [M_TDATA_W-1:0]    out_data_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    sdpc_core u_core (
        .cur               (state_reg),
        .open_pressed      (open_reg),
        .close_pressed     (close_reg),
        .now_ms            (now_reg),
        .step_interval     (interval_reg),
        .open_target_steps (target_reg),
        .nxt               (state_next),
        .stepped           (stepped)
    );

    assign out_data_next = {1'b0, stepped, state_next.position,
                            mode_code(state_next.mode), state_next.coil};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= STEP_INTERVAL_RST;
            target_reg <= OPEN_TARGET_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STEP_INTERVAL: interval_reg <= cfg_data;
                REG_OPEN_TARGET:   target_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            open_reg <= s_tdata[0];
            close_reg <= s_tdata[1];
            now_reg <= s_tdata[33:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MOTION_IDLE, last_time: '0, position: '0,
                           phase: '0, coil: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/sdpc_core.sv */
// sdpc_core: next-state logic for one button/time sample: mode select,
// step timer check, phase and position update; uses sdpc_pkg
`default_nettype none

module sdpc_core
    import sdpc_pkg::*;
(
    input  sdpc_state_t              cur,
    input  logic                     open_pressed,
    input  logic                     close_pressed,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic [CFG_DATA_W-1:0]    step_interval,
    input  logic [CFG_DATA_W-1:0]    open_target_steps,
    output sdpc_state_t              nxt,
    output logic                     stepped
);

    motion_t              mode_sel;
    logic [TIME_W-1:0]    elapsed;
    logic [POS_W-1:0]     pos_up;
    logic [POS_W-1:0]     pos_dn;
    logic [PHASE_W-1:0]   phase_new;
    logic                 stop;

    always_comb begin
        mode_sel = cur.mode;
        if (open_pressed && (cur.position < open_target_steps)) begin
            mode_sel = MOTION_OPENING;
        end
        if (close_pressed && (cur.position != '0)) begin
            mode_sel = MOTION_CLOSING;
        end
    end

    assign elapsed = now_ms - cur.last_time;
    assign stepped = (mode_sel != MOTION_IDLE)
                     && (elapsed >= TIME_W'(step_interval));
    assign pos_up = (cur.position == '1) ? cur.position : cur.position + POS_W'(1);
    assign pos_dn = (cur.position == '0) ? cur.position : cur.position - POS_W'(1);

    always_comb begin
        nxt = cur;
        nxt.mode = mode_sel;
        phase_new = cur.phase;
        stop = 1'b0;
        if (stepped) begin
            nxt.last_time = now_ms;
            if (mode_sel == MOTION_OPENING) begin
                phase_new = cur.phase - PHASE_W'(1);
                nxt.position = pos_up;
                stop = (pos_up >= open_target_steps);
            end else begin
                phase_new = cur.phase + PHASE_W'(1);
                nxt.position = pos_dn;
                stop = (pos_dn == '0);
            end
            nxt.phase = phase_new;
            if (stop) begin
                nxt.mode = MOTION_IDLE;
                nxt.coil = '0;
            end else begin
                nxt.coil = coil_lookup(phase_new);
            end
        end
    end

endmodule

`default_nettype wire

/* bench/sdpc_door_checker.sv */
// sdpc_door_checker: watches the input, result and register write channels
// of the stepper door position controller, predicts each result and compares
// depends on sdpc_pkg for widths, register indexes and mode codes
`timescale 1ns / 100ps

module sdpc_door_checker
    import sdpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    results_checked,
    output int                    steps_seen,
    output int                    stops_seen
);

    // packed from the top bit down, so coil lands in the low bits
    typedef struct packed {
        logic              stepped;
        logic [POS_W-1:0]  position;
        logic [MODE_W-1:0] mode;
        logic [COIL_W-1:0] coil;
    } door_result_t;

    // half-step coil patterns, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_COILS = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

    logic [CFG_DATA_W-1:0] interval_ms;
    logic [CFG_DATA_W-1:0] target_steps;
    logic [MODE_W-1:0]     motion;
    logic [TIME_W-1:0]     last_step_ms;
    logic [POS_W-1:0]      position;
    logic [PHASE_W-1:0]    phase;
    logic [COIL_W-1:0]     coils;

    door_result_t expected_door_results[$];

    initial begin
        fail_count = 0;
        pending = 0;
        results_checked = 0;
        steps_seen = 0;
        stops_seen = 0;
    end

    task automatic advance_door(input logic open_btn, input logic close_btn,
                                input logic [TIME_W-1:0] now_ms, output door_result_t res);
        logic              stop;
        logic [TIME_W-1:0] elapsed;
        stop = 1'b0;
        res.stepped = 1'b0;
        if (open_btn && position < target_steps)
            motion = DOOR_MODE_OPENING;
        if (close_btn && position != '0)
            motion = DOOR_MODE_CLOSING;
        elapsed = now_ms - last_step_ms;
        if (motion != DOOR_MODE_IDLE && elapsed >= {16'h0, interval_ms}) begin
            last_step_ms = now_ms;
            res.stepped = 1'b1;
            steps_seen++;
            if (motion == DOOR_MODE_OPENING) begin
                phase = phase - 3'd1;
                if (position != 16'hFFFF)
                    position = position + 16'd1;
                stop = (position >= target_steps);
            end else begin
                phase = phase + 3'd1;
                if (position != '0)
                    position = position - 16'd1;
                stop = (position == '0);
            end
            if (stop) begin
                motion = DOOR_MODE_IDLE;
                coils = '0;
                stops_seen++;
            end else begin
                coils = HALF_STEP_COILS[phase*4 +: 4];
            end
        end
        res.coil = coils;
        res.mode = motion;
        res.position = position;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        door_result_t want;
        door_result_t got;
        if (!aresetn) begin
            interval_ms = STEP_INTERVAL_RST;
            target_steps = OPEN_TARGET_RST;
            motion = DOOR_MODE_IDLE;
            last_step_ms = '0;
            position = '0;
            phase = '0;
            coils = '0;
            expected_door_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STEP_INTERVAL: interval_ms = cfg_data;
                    REG_OPEN_TARGET:   target_steps = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = door_result_t'(m_tdata[22:0]);
                if (expected_door_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transaction with nothing expected, actual %h",
                             $time, m_tdata);
                end else begin
                    want = expected_door_results.pop_front();
                    results_checked++;
                    check_field("coil_pattern", 16'(want.coil), 16'(got.coil));
                    check_field("door_mode", 16'(want.mode), 16'(got.mode));
                    check_field("door_position", want.position, got.position);
                    check_field("stepped", 16'(want.stepped), 16'(got.stepped));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_door(s_tdata[0], s_tdata[1], s_tdata[33:2], want);
                expected_door_results.push_back(want);
            end
        end
        pending = expected_door_results.size();
    end

endmodule

/* bench/tb_stepper_door_position_controller.sv */
// tb_stepper_door_position_controller: stimulus and verdict for the stepper
// door position controller; uses sdpc_pkg, the block and sdpc_door_checker
`timescale 1ns / 100ps

module tb_stepper_door_position_controller;
    import sdpc_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 125;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int steps_seen;
    int stops_seen;

    logic [TIME_W-1:0]     clock_ms;
    logic [CFG_DATA_W-1:0] cur_interval;
    int items_sent;
    int settings_used;
    int calm_left;
    int idle_cycles;

    stepper_door_position_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdpc_door_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .steps_seen      (steps_seen),
        .stops_seen      (stops_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // stall pattern on the result side
    initial begin
        int run;
        int stall;
        int pick;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            run = $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run) @(negedge aclk);
            pick = $urandom_range(0, 9);
            stall = (pick < 5) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic open_btn, input logic close_btn,
                             input logic [TIME_W-1:0] now_ms);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        clock_ms = now_ms;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, now_ms, close_btn, open_btn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == REG_STEP_INTERVAL)
            cur_interval = val;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] interval_val,
                                 input logic [CFG_DATA_W-1:0] target_val);
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_STEP_INTERVAL, interval_val);
            write_reg(REG_OPEN_TARGET, target_val);
        end else begin
            write_reg(REG_OPEN_TARGET, target_val);
            write_reg(REG_STEP_INTERVAL, interval_val);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNMAPPED, 16'($urandom));
        settings_used++;
    endtask

    task automatic random_phase(input int count);
        int pick;
        int run_left;
        int run_kind;
        logic open_btn;
        logic close_btn;
        logic [TIME_W-1:0] dt;
        logic [CFG_DATA_W-1:0] interval_val;
        logic [CFG_DATA_W-1:0] target_val;
        pick = $urandom_range(0, 9);
        interval_val = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                       (pick < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        pick = $urandom_range(0, 9);
        target_val = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                     (pick < 8) ? 16'($urandom_range(1, 24)) :
                     (pick == 8) ? 16'($urandom_range(25, 200)) : 16'($urandom);
        set_registers(interval_val, target_val);
        run_left = 0;
        run_kind = 0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                pick = $urandom_range(0, 9);
                run_kind = (pick < 4) ? 0 : (pick < 8) ? 1 : 2;
                run_left = $urandom_range(1, 20);
            end
            case (run_kind)
                0: begin
                    open_btn = 1'b1;
                    close_btn = ($urandom_range(0, 19) == 0);
                end
                1: begin
                    open_btn = ($urandom_range(0, 19) == 0);
                    close_btn = 1'b1;
                end
                default: begin
                    open_btn = ($urandom_range(0, 3) == 0);
                    close_btn = ($urandom_range(0, 3) == 0);
                end
            endcase
            // in open and close runs the buttons are released half the time, the door keeps moving
            if (run_kind != 2 && $urandom_range(0, 1) == 1) begin
                open_btn = 1'b0;
                close_btn = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                dt = $urandom_range(0, 2);
            else if (pick < 70)
                dt = {16'h0, cur_interval};
            else if (pick < 80)
                dt = {16'h0, cur_interval} + 32'd1;
            else if (pick < 90)
                dt = (cur_interval == 0) ? 32'd0 : {16'h0, cur_interval} - 32'd1;
            else
                dt = $urandom;
            send_item(open_btn, close_btn, clock_ms + dt);
            run_left--;
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        items_sent = 0;
        settings_used = 1;
        calm_left = 0;
        clock_ms = '0;
        cur_interval = STEP_INTERVAL_RST;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: button priority, start without a step, time wrap
        send_item(1'b0, 1'b0, 32'd0);
        send_item(1'b0, 1'b1, 32'd0);
        send_item(1'b1, 1'b0, 32'd1);
        send_item(1'b0, 1'b0, 32'd2);
        send_item(1'b1, 1'b1, 32'd3);
        send_item(1'b0, 1'b0, 32'd4);
        send_item(1'b1, 1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 1'b0, 32'd0);
        send_item(1'b0, 1'b0, 32'd1);
        drain();

        // zero interval, small target: finish opening at the target, close back and stop at the closed end
        write_reg(REG_STEP_INTERVAL, 16'd0);
        write_reg(REG_OPEN_TARGET, 16'd3);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        settings_used++;
        send_item(1'b0, 1'b0, 32'd1);
        send_item(1'b0, 1'b0, 32'd1);
        send_item(1'b1, 1'b0, 32'd1);
        send_item(1'b0, 1'b1, 32'd1);
        send_item(1'b0, 1'b0, 32'd1);
        send_item(1'b0, 1'b0, 32'd1);
        drain();

        // target lowered under the position while still opening
        write_reg(REG_STEP_INTERVAL, 16'd1);
        write_reg(REG_OPEN_TARGET, 16'd10);
        settings_used++;
        send_item(1'b1, 1'b0, 32'd2);
        send_item(1'b0, 1'b0, 32'd3);
        send_item(1'b0, 1'b0, 32'd4);
        send_item(1'b0, 1'b0, 32'd5);
        drain();
        write_reg(REG_OPEN_TARGET, 16'd2);
        settings_used++;
        send_item(1'b0, 1'b0, 32'd6);
        drain();

        // widest settings
        write_reg(REG_STEP_INTERVAL, 16'hFFFF);
        write_reg(REG_OPEN_TARGET, 16'hFFFF);
        settings_used++;
        send_item(1'b0, 1'b1, 32'd7);
        send_item(1'b0, 1'b0, 32'd65541);
        send_item(1'b1, 1'b0, 32'd65542);
        send_item(1'b0, 1'b0, 32'hFFFF_FFFF);
        drain();

        // zero target while opening
        write_reg(REG_OPEN_TARGET, 16'd0);
        settings_used++;
        send_item(1'b1, 1'b0, 32'h0000_FFFF);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_ITEMS);

        repeat (10) @(posedge aclk);
        $display("sent %0d items over %0d register settings, %0d results checked",
                 items_sent, settings_used, results_checked);
        $display("predicted %0d half-steps, %0d of them ending at a door end",
                 steps_seen, stops_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sdpc_pkg.sv
hw/rtl/sdpc_core.sv
hw/rtl/stepper_door_position_controller.sv
bench/sdpc_door_checker.sv
bench/tb_stepper_door_position_controller.sv
